>>> src/pwoc_pkg.sv
// pwoc_pkg: shared types and constants for the pid controller with output clamp
// payload structs, register indexes, gain/limit bundle; no dependencies
`timescale 1ns / 1ps

package pwoc_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned IndexW = 3;

  // register indexes on the configuration port
  localparam logic [IndexW-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [IndexW-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [IndexW-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [IndexW-1:0] REG_OUT_UPPER  = 3'd3;
  localparam logic [IndexW-1:0] REG_OUT_LOWER  = 3'd4;

  localparam logic signed [DataW-1:0] OUT_UPPER_RST = 16'sh7FFF;
  localparam logic signed [DataW-1:0] OUT_LOWER_RST = 16'sh8000;

  typedef struct packed {
    logic signed [DataW-1:0] track_error;
    logic [DataW-1:0]        new_interval;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive_value;
    logic [DataW-1:0]        interval_used;
  } out_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] prop_gain;
    logic signed [DataW-1:0] integ_gain;
    logic signed [DataW-1:0] deriv_gain;
    logic signed [DataW-1:0] out_upper;
    logic signed [DataW-1:0] out_lower;
  } gains_t;

endpackage

>>> src/pid_with_output_clamp_core.sv
// pid_with_output_clamp_core: pid controller with saturating integrator and output clamp
// sequencer around one shared multiplier and a serial divider
// depends on pwoc_pkg, pwoc_regs, pwoc_mul, pwoc_div
//
//   channel | direction | handshake             | beat
//   in      | input     | in_valid / in_ready   | in_data  (track_error, new_interval)
//   out     | output    | out_valid / out_ready | out_data (drive_value, interval_used)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// the 32-step serial divider for the derivative term and four multiplier passes set the time
// from an input beat with a nonzero interval to its result; with the interval zero the divider
// and the derivative multiplier pass are skipped
// in_ready is high only when the sequencer is idle; cfg_ready is always high
// the result sits in an output register, so the next beat is taken while it waits
// reset (rst, synchronous) clears the state, the gains and sets the limits to full range
`timescale 1ns / 1ps

module pid_with_output_clamp_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pwoc_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pwoc_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pwoc_pkg::IndexW-1:0] cfg_index,
  input  logic [pwoc_pkg::DataW-1:0]  cfg_data
);
  import pwoc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL_P  = 9'b000000010,
    S_MUL_I  = 9'b000000100,
    S_MUL_ID = 9'b000001000,
    S_INTEG  = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_MUL_D  = 9'b001000000,
    S_ADD_D  = 9'b010000000,
    S_CLAMP  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  gains_t gains;

  logic signed [15:0] err;
  logic signed [16:0] diff;
  logic signed [15:0] last_error;
  logic [15:0]        stored_interval;
  logic signed [31:0] integral_sum;
  logic signed [51:0] sum;

  logic signed [32:0] op_a;
  logic signed [16:0] op_b;
  logic signed [49:0] prod;

  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quo;
  logic [16:0]        abs_diff;
  logic signed [32:0] q_mag;
  logic signed [32:0] q_signed;

  logic signed [33:0] inc;
  logic signed [35:0] acc;
  logic signed [31:0] acc_sat;

  logic signed [43:0] s_val;
  logic signed [43:0] lo_ext;
  logic signed [43:0] hi_ext;
  logic signed [15:0] drive;
  logic               out_free;

  pwoc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  pwoc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign abs_diff  = diff[16] ? 17'(-diff) : diff;
  assign div_start = (state == S_INTEG) && (stored_interval != '0);

  pwoc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({abs_diff[15:0], 16'h0000}),
    .divisor  (stored_interval),
    .done     (div_done),
    .quotient (div_quo)
  );

  // quotient truncates toward zero, so the sign goes back on the magnitude
  assign q_mag    = {1'b0, div_quo};
  assign q_signed = diff[16] ? -q_mag : q_mag;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_MUL_P: begin
        op_a = {{17{err[15]}}, err};
        op_b = {gains.prop_gain[15], gains.prop_gain};
      end
      S_MUL_I: begin
        op_a = {{17{err[15]}}, err};
        op_b = {gains.integ_gain[15], gains.integ_gain};
      end
      S_MUL_ID: begin
        op_a = {prod[31], prod[31:0]};
        op_b = {1'b0, stored_interval};
      end
      S_MUL_D: begin
        op_a = q_signed;
        op_b = {gains.deriv_gain[15], gains.deriv_gain};
      end
      default: ;
    endcase
  end

  // integrator increment is floor(ig*e*d / 2^16), then 32-bit saturation
  assign inc = prod[49:16];
  assign acc = {{4{integral_sum[31]}}, integral_sum} + {{2{inc[33]}}, inc};
  always_comb begin
    if (acc > 36'sh0_7FFF_FFFF) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc < -36'sh0_8000_0000) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = acc[31:0];
    end
  end

  // clamp: below lower wins, so crossed limits resolve as the lower bound first
  assign s_val  = sum[51:8];
  assign lo_ext = {{28{gains.out_lower[15]}}, gains.out_lower};
  assign hi_ext = {{28{gains.out_upper[15]}}, gains.out_upper};
  always_comb begin
    if (s_val < lo_ext) begin
      drive = gains.out_lower;
    end else if (s_val > hi_ext) begin
      drive = gains.out_upper;
    end else begin
      drive = s_val[15:0];
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_MUL_P;
      S_MUL_P:  state_next = S_MUL_I;
      S_MUL_I:  state_next = S_MUL_ID;
      S_MUL_ID: state_next = S_INTEG;
      S_INTEG:  state_next = (stored_interval != '0) ? S_DIV : S_CLAMP;
      S_DIV:    if (div_done) state_next = S_MUL_D;
      S_MUL_D:  state_next = S_ADD_D;
      S_ADD_D:  state_next = S_CLAMP;
      S_CLAMP:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      last_error      <= '0;
      stored_interval <= '0;
      integral_sum    <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        last_error <= in_data.track_error;
        if (in_data.new_interval != '0) begin
          stored_interval <= in_data.new_interval;
        end
      end
      if (state == S_INTEG) begin
        integral_sum <= acc_sat;
      end
      if (state == S_CLAMP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      err  <= in_data.track_error;
      diff <= {in_data.track_error[15], in_data.track_error} - {last_error[15], last_error};
    end
    case (state)
      S_MUL_I: sum <= {{2{prod[49]}}, prod};
      S_INTEG: sum <= sum + {{20{acc_sat[31]}}, acc_sat};
      S_ADD_D: sum <= sum + {{2{prod[49]}}, prod};
      default: ;
    endcase
    if (state == S_CLAMP && out_free) begin
      out_data.drive_value   <= drive;
      out_data.interval_used <= stored_interval;
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  a_zero_interval_skips_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_INTEG && stored_interval == '0) |=> (state == S_CLAMP))
    else $error("zero interval did not skip the derivative term");

  a_accept_starts_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL_P))
    else $error("accepted beat did not start the sequence");

  a_result_in_limits: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (gains.out_lower > gains.out_upper)
      || (out_data.drive_value >= gains.out_lower && out_data.drive_value <= gains.out_upper))
    else $error("drive value outside the configured limits");

  a_interval_nonzero_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (stored_interval != '0))
    else $error("divide step entered with zero interval");

endmodule

>>> src/pwoc_regs.sv
// pwoc_regs: configuration register bank for gains and output limits
// depends on pwoc_pkg
`timescale 1ns / 1ps

module pwoc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pwoc_pkg::IndexW-1:0]   cfg_index,
  input  logic [pwoc_pkg::DataW-1:0]    cfg_data,
  output pwoc_pkg::gains_t              gains
);
  import pwoc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop_gain  <= '0;
      gains.integ_gain <= '0;
      gains.deriv_gain <= '0;
      gains.out_upper  <= OUT_UPPER_RST;
      gains.out_lower  <= OUT_LOWER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  gains.prop_gain  <= $signed(cfg_data);
        REG_INTEG_GAIN: gains.integ_gain <= $signed(cfg_data);
        REG_DERIV_GAIN: gains.deriv_gain <= $signed(cfg_data);
        REG_OUT_UPPER:  gains.out_upper  <= $signed(cfg_data);
        REG_OUT_LOWER:  gains.out_lower  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

>>> src/pwoc_mul.sv
// pwoc_mul: shared signed multiplier with registered product
// no package dependencies
`timescale 1ns / 1ps

module pwoc_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [16:0] op_b,
  output logic signed [49:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

>>> src/pwoc_div.sv
// pwoc_div: restoring divider, one quotient bit per cycle, 32-bit by 16-bit unsigned
// no package dependencies
`timescale 1ns / 1ps

module pwoc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [15:0] dsr;
  logic [15:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] rem_sh;
  logic        fits;

  assign rem_sh   = {rem, quotient[31]};
  assign fits     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr      <= divisor;
      rem      <= '0;
      quotient <= dividend;
      cnt      <= 5'd31;
    end else if (busy) begin
      // remainder stays below the divisor, so 16 bits hold it
      rem      <= fits ? 16'(rem_sh - {1'b0, dsr}) : rem_sh[15:0];
      quotient <= {quotient[30:0], fits};
      cnt      <= cnt - 5'd1;
    end
  end

endmodule

>>> tb/pid_drive_checker.sv
// pid_drive_checker: predicts the clamped drive value of every accepted input beat
// and compares it with the output channel, counting mismatches; depends on pwoc_pkg
`timescale 1ns / 1ps

module pid_drive_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  pwoc_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  pwoc_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pwoc_pkg::IndexW-1:0]   cfg_index,
  input  logic [pwoc_pkg::DataW-1:0]    cfg_data,
  output int                            mismatches,
  output int                            drives_owed
);
  import pwoc_pkg::*;

  localparam longint IntegMax = (longint'(1) <<< 31) - 1;
  localparam longint IntegMin = -(longint'(1) <<< 31);

  gains_t                  gains;
  logic signed [DataW-1:0] prev_error;
  logic signed [31:0]      integ_acc;
  logic [DataW-1:0]        held_interval;
  out_item_t               owed_drives[$];
  out_item_t               want;

  // advances the controller state by one sample and returns the drive it should produce
  function automatic out_item_t predict_drive(input in_item_t item);
    longint    err, dt, slope, p_term, d_term, step, acc, total, lo, hi, clamped;
    out_item_t res;
    if (item.new_interval != '0) held_interval = item.new_interval;
    err    = $signed(item.track_error);
    dt     = held_interval;
    p_term = $signed(gains.prop_gain) * err;
    d_term = 0;
    // derivative only once an interval is known; quotient truncates towards zero
    if (dt != 0) begin
      slope  = ((err - $signed(prev_error)) * 65536) / dt;
      d_term = $signed(gains.deriv_gain) * slope;
    end
    step = ($signed(gains.integ_gain) * err * dt) >>> 16;
    acc  = $signed(integ_acc) + step;
    if (acc > IntegMax) acc = IntegMax;
    if (acc < IntegMin) acc = IntegMin;
    integ_acc = acc[31:0];
    total = (p_term + d_term + acc) >>> 8;
    lo    = $signed(gains.out_lower);
    hi    = $signed(gains.out_upper);
    // lower limit wins first, so crossed limits fall out of the same test
    if (total < lo) clamped = lo;
    else if (total > hi) clamped = hi;
    else clamped = total;
    prev_error        = item.track_error;
    res.drive_value   = clamped[DataW-1:0];
    res.interval_used = held_interval;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gains         = '{prop_gain: '0, integ_gain: '0, deriv_gain: '0,
                        out_upper: OUT_UPPER_RST, out_lower: OUT_LOWER_RST};
      prev_error    = '0;
      integ_acc     = '0;
      held_interval = '0;
      owed_drives.delete();
      mismatches    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:  gains.prop_gain  = cfg_data;
          REG_INTEG_GAIN: gains.integ_gain = cfg_data;
          REG_DERIV_GAIN: gains.deriv_gain = cfg_data;
          REG_OUT_UPPER:  gains.out_upper  = cfg_data;
          REG_OUT_LOWER:  gains.out_lower  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_drives.size() == 0) begin
          mismatches++;
          $display("%0t: output beat with nothing expected: drive %0d interval %0d",
                   $time, out_data.drive_value, out_data.interval_used);
        end else begin
          want = owed_drives.pop_front();
          if (out_data.drive_value !== want.drive_value) begin
            mismatches++;
            $display("%0t: drive_value expected %0d, got %0d",
                     $time, want.drive_value, out_data.drive_value);
          end
          if (out_data.interval_used !== want.interval_used) begin
            mismatches++;
            $display("%0t: interval_used expected %0d, got %0d",
                     $time, want.interval_used, out_data.interval_used);
          end
        end
      end
      if (in_valid && in_ready) owed_drives.push_back(predict_drive(in_data));
    end
    drives_owed = owed_drives.size();
  end

endmodule

>>> tb/pid_with_output_clamp_core_tb.sv
// pid_with_output_clamp_core_tb: drives samples and register writes into the pid core
// and gives the verdict; depends on pwoc_pkg, pid_drive_checker, pid_with_output_clamp_core
`timescale 1ns / 1ps

module pid_with_output_clamp_core_tb;
  import pwoc_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int RandSamples = 1200;
  localparam int CalmFrom    = 1050;
  localparam int SettleWait  = 60;

  localparam logic [IndexW-1:0] REG_UNUSED_FIRST = REG_OUT_LOWER + 3'd1;
  localparam logic [IndexW-1:0] REG_UNUSED_LAST  = {IndexW{1'b1}};

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IndexW-1:0]  cfg_index = '0;
  logic [DataW-1:0]   cfg_data  = '0;

  int mismatches;
  int drives_owed;
  int cycle_count = 0;
  int stall_left  = 0;
  bit send_gaps   = 1'b0;
  bit recv_stalls = 1'b0;

  pid_with_output_clamp_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pid_drive_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .drives_owed (drives_owed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL pid_with_output_clamp_core");
      $finish;
    end
  end

  // receiver back-pressure: out_ready drops in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // random value of random magnitude, so small and full-scale values both turn up
  function automatic logic [DataW-1:0] rand_field(input bit sext);
    int unsigned      span;
    logic [DataW-1:0] raw;
    span = $urandom_range(1, DataW);
    raw  = DataW'($urandom);
    raw  = raw << (DataW - span);
    if (sext) return $signed(raw) >>> (DataW - span);
    return raw >> (DataW - span);
  endfunction

  function automatic logic [DataW-1:0] pick_reg();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return rand_field(1'b1);
    endcase
  endfunction

  // called at a falling edge; valid is left high so a following beat goes out back to back
  task automatic send_sample(input logic [DataW-1:0] err, input logic [DataW-1:0] iv);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{track_error: err, new_interval: iv};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (drives_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [DataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic signed [DataW-1:0] err;
    logic [DataW-1:0]        iv;
    logic [DataW-1:0]        hi;
    logic [DataW-1:0]        lo;
    logic [DataW-1:0]        tmp;
    int                      sent;
    int                      phase_len;
    int                      delta;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    recv_stalls <= 1'b1;

    // gains still at their reset values
    send_sample(16'h04D2, 16'h0000);
    drain();
    write_reg(REG_PROP_GAIN, 16'h0100);
    write_reg(REG_INTEG_GAIN, 16'h0080);
    write_reg(REG_DERIV_GAIN, 16'h0040);
    write_reg(REG_OUT_UPPER, 16'h7FFF);
    write_reg(REG_OUT_LOWER, 16'h8000);
    // no interval yet, then the smallest and largest intervals
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h7FFF, 16'h0001);
    send_sample(16'h8000, 16'hFFFF);
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'h0101, 16'h0000);

    // crossed limits: upper below lower
    drain();
    write_reg(REG_INTEG_GAIN, 16'h0000);
    write_reg(REG_OUT_UPPER, 16'hFF00);
    write_reg(REG_OUT_LOWER, 16'h0100);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0180, 16'h0000);

    // integrator into both bounds
    drain();
    write_reg(REG_INTEG_GAIN, 16'h7FFF);
    write_reg(REG_OUT_UPPER, 16'h7FFF);
    write_reg(REG_OUT_LOWER, 16'h8000);
    repeat (4) send_sample(16'h7FFF, 16'hFFFF);
    repeat (5) send_sample(16'h8000, 16'h0000);

    err  = '0;
    sent = 0;
    while (sent < RandSamples) begin
      drain();
      write_reg(REG_PROP_GAIN, pick_reg());
      write_reg(REG_INTEG_GAIN, pick_reg());
      write_reg(REG_DERIV_GAIN, pick_reg());
      hi = pick_reg();
      lo = pick_reg();
      // mostly ordered limits, sometimes left crossed
      if ($urandom_range(0, 3) != 0 && $signed(lo) > $signed(hi)) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      write_reg(REG_OUT_UPPER, hi);
      write_reg(REG_OUT_LOWER, lo);
      if ($urandom_range(0, 3) == 0)
        write_reg(IndexW'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), rand_field(1'b1));
      if (sent >= CalmFrom) begin
        send_gaps   = 1'b0;
        recv_stalls <= 1'b0;
      end else begin
        send_gaps   = $urandom_range(0, 2) != 0;
        recv_stalls <= $urandom_range(0, 2) != 0;
      end
      phase_len = $urandom_range(30, 100);
      repeat (phase_len) begin
        // slow trajectories keep the derivative term away from its extremes
        if ($urandom_range(0, 1) == 0) begin
          delta = $urandom_range(0, 64);
          err   = err + DataW'(delta - 32);
        end else begin
          err = rand_field(1'b1);
        end
        case ($urandom_range(0, 2))
          0:       iv = '0;
          default: iv = rand_field(1'b0);
        endcase
        send_sample(err, iv);
        sent++;
      end
    end

    drain();
    repeat (SettleWait) @(negedge clk);
    if (mismatches == 0) $display("PASS pid_with_output_clamp_core");
    else $display("FAIL pid_with_output_clamp_core");
    $finish;
  end

endmodule
